FILE: hw/rtl/tcwqs_pkg.sv
package tcwqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int ID_W   = 32;
    localparam int AGE_W  = 7;
    localparam int TURN_W = 4;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 7;

    localparam logic [AGE_W-1:0]  HIGH_THR_RST = 7'd50;
    localparam logic [AGE_W-1:0]  MID_THR_RST  = 7'd40;
    localparam logic [TURN_W-1:0] HIGH_TURNS_RST = 4'd3;
    localparam logic [TURN_W-1:0] MID_TURNS_RST  = 4'd2;

    localparam logic [1:0] REG_HIGH_THR   = 2'd0;
    localparam logic [1:0] REG_MID_THR    = 2'd1;
    localparam logic [1:0] REG_HIGH_TURNS = 2'd2;
    localparam logic [1:0] REG_MID_TURNS  = 2'd3;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_SERVE    = 2'd1;
    localparam logic [1:0] OP_WITHDRAW = 2'd2;

    localparam logic [2:0] ST_REGISTERED = 3'd0;
    localparam logic [2:0] ST_DUPLICATE  = 3'd1;
    localparam logic [2:0] ST_SERVED     = 3'd2;
    localparam logic [2:0] ST_NONE       = 3'd3;
    localparam logic [2:0] ST_WITHDRAWN  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [2:0] ST_FULL       = 3'd6;

    localparam logic [1:0] CLS_HIGH = 2'd0;
    localparam logic [1:0] CLS_MID  = 2'd1;
    localparam logic [1:0] CLS_LOW  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } t_entry;

    typedef struct packed {
        logic             ok;
        logic [1:0]       cls;
        logic [CNT_W-1:0] hcnt;
        logic [CNT_W-1:0] mcnt;
        logic [1:0]       lflag;
    } t_pick;

endpackage

FILE: hw/rtl/three_class_weighted_queue_scheduler.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------------
// command  | in        | start & !busy              | i_op, i_person_id, i_age
// result   | out       | o_done, one cycle          | o_status, o_served_id, o_served_age,
//          |           |                            | o_served_class
// config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// All three classes share one entry memory with a registered read.
// Register: searches the chosen class for the id, then writes the new entry at its tail.
// Serve: reads the head of the picked class, then shifts the rest down one slot.
// Withdraw: searches the classes in order high, mid, low, then shifts the hit class down over the found slot.
// Serve with nothing waiting and op 3 answer from the idle state without a scan. Reset is
// synchronous, active low, and needs no clearing pass. Results cannot be held off.
module three_class_weighted_queue_scheduler #(
    parameter int QUEUE_DEPTH = tcwqs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [tcwqs_pkg::ID_W-1:0]    i_person_id,
    input  logic [tcwqs_pkg::AGE_W-1:0]   i_age,
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [tcwqs_pkg::ID_W-1:0]    o_served_id,
    output logic [tcwqs_pkg::AGE_W-1:0]   o_served_age,
    output logic [1:0]                    o_served_class,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [tcwqs_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int IW = $clog2(QUEUE_DEPTH + 1);
    localparam int MD = 3 * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);
    localparam logic [AW-1:0] BASE_MID = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] BASE_LOW = AW'(2 * QUEUE_DEPTH);
    localparam logic [IW-1:0] DEPTH_I  = IW'(QUEUE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    localparam int CW = tcwqs_pkg::CNT_W;

    tcwqs_pkg::t_entry r_mem [MD];
    tcwqs_pkg::t_entry r_rd_data;

    logic [1:0]                         r_state, n_state;
    logic [1:0]                         r_op, n_op;
    logic [tcwqs_pkg::ID_W-1:0]         r_id, n_id;
    logic [tcwqs_pkg::AGE_W-1:0]        r_age, n_age;
    logic [1:0]                         r_cls, n_cls;
    logic [IW-1:0]                      r_idx, n_idx;
    logic [IW-1:0]                      r_pos, n_pos;
    logic                               r_rd_vld, n_rd_vld;
    logic [IW-1:0]                      r_rd_pos, n_rd_pos;
    logic [IW-1:0]                      r_occ [3];
    logic [IW-1:0]                      n_occ [3];
    logic [CW-1:0]                      r_hcnt, n_hcnt;
    logic [CW-1:0]                      r_mcnt, n_mcnt;
    logic [1:0]                         r_lflag, n_lflag;

    logic [tcwqs_pkg::AGE_W-1:0]        r_hi_thr, r_mid_thr;
    logic [tcwqs_pkg::TURN_W-1:0]       r_hi_turns, r_mid_turns;

    logic                               r_done, n_done;
    logic [2:0]                         r_status, n_status;
    logic [tcwqs_pkg::ID_W-1:0]         r_oid, n_oid;
    logic [tcwqs_pkg::AGE_W-1:0]        r_oage, n_oage;
    logic [1:0]                         r_ocls, n_ocls;

    logic                               mem_we, rd_en;
    logic [AW-1:0]                      mem_waddr, mem_raddr, base;
    tcwqs_pkg::t_entry                  mem_wdata;
    logic [IW-1:0]                      occ_cur;
    logic [1:0]                         age_cls;
    logic [CW-1:0]                      t1, t2;
    logic                               hit, more;
    tcwqs_pkg::t_pick                   pk_first, pk;

    function automatic tcwqs_pkg::t_pick pick_once(
        input logic [CW-1:0] hcnt,
        input logic [CW-1:0] mcnt,
        input logic [1:0]    lflag,
        input logic          e0,
        input logic          e1,
        input logic          e2,
        input logic [CW-1:0] lim1,
        input logic [CW-1:0] lim2
    );
        tcwqs_pkg::t_pick p;
        p.ok    = 1'b0;
        p.cls   = tcwqs_pkg::CLS_HIGH;
        p.hcnt  = hcnt;
        p.mcnt  = mcnt;
        p.lflag = lflag;
        if (e0 && p.hcnt <= lim1) begin
            p.hcnt = lim1 + CW'(1);
        end
        if (e1 && p.mcnt <= lim2) begin
            p.mcnt = lim2 + CW'(1);
        end
        if (e2 && p.lflag <= 2'd1) begin
            p.lflag = 2'd2;
        end
        priority if (p.hcnt <= lim1) begin
            p.hcnt  = p.hcnt + CW'(1);
            p.lflag = 2'd1;
            p.cls   = tcwqs_pkg::CLS_HIGH;
            p.ok    = 1'b1;
        end else if (p.mcnt <= lim2) begin
            p.mcnt  = p.mcnt + CW'(1);
            p.cls   = tcwqs_pkg::CLS_MID;
            p.ok    = 1'b1;
        end else if (p.lflag == 2'd1) begin
            p.lflag = 2'd2;
            p.hcnt  = CW'(1);
            p.mcnt  = CW'(1);
            p.cls   = tcwqs_pkg::CLS_LOW;
            p.ok    = 1'b1;
        end
        return p;
    endfunction

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_served_id    = r_oid;
    assign o_served_age   = r_oage;
    assign o_served_class = r_ocls;

    assign t1 = (r_hi_turns == '0) ? CW'(1) : CW'(r_hi_turns);
    assign t2 = (r_mid_turns == '0) ? CW'(1) : CW'(r_mid_turns);

    assign age_cls = (i_age > r_hi_thr)  ? tcwqs_pkg::CLS_HIGH :
                     (i_age > r_mid_thr) ? tcwqs_pkg::CLS_MID  : tcwqs_pkg::CLS_LOW;

    assign occ_cur = r_occ[r_cls];
    assign base    = (r_cls == tcwqs_pkg::CLS_HIGH) ? '0 :
                     (r_cls == tcwqs_pkg::CLS_MID)  ? BASE_MID : BASE_LOW;
    assign mem_raddr = base + AW'(r_idx);
    assign hit  = r_rd_vld && (r_rd_data.id == r_id);
    assign more = (r_idx < occ_cur);

    always_comb begin
        pk_first = pick_once(r_hcnt, r_mcnt, r_lflag, r_occ[0] == '0, r_occ[1] == '0,
                             r_occ[2] == '0, t1, t2);
        pk = pk_first;
        if (!pk_first.ok) begin
            pk = pick_once(CW'(1), CW'(1), 2'd1, r_occ[0] == '0, r_occ[1] == '0,
                           r_occ[2] == '0, t1, t2);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_id     = r_id;
        n_age    = r_age;
        n_cls    = r_cls;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_rd_vld = 1'b0;
        n_rd_pos = r_rd_pos;
        n_occ    = r_occ;
        n_hcnt   = r_hcnt;
        n_mcnt   = r_mcnt;
        n_lflag  = r_lflag;
        n_done   = 1'b0;
        n_status = r_status;
        n_oid    = r_oid;
        n_oage   = r_oage;
        n_ocls   = r_ocls;
        mem_we    = 1'b0;
        mem_waddr = base + AW'(occ_cur);
        mem_wdata = '{id: r_id, age: r_age};
        rd_en     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_op;
                    n_id  = i_person_id;
                    n_age = i_age;
                    n_idx = '0;
                    n_pos = '0;
                    unique case (i_op)
                        tcwqs_pkg::OP_REGISTER: begin
                            n_cls   = age_cls;
                            n_state = S_SCAN;
                        end
                        tcwqs_pkg::OP_WITHDRAW: begin
                            n_cls   = tcwqs_pkg::CLS_HIGH;
                            n_state = S_SCAN;
                        end
                        tcwqs_pkg::OP_SERVE: begin
                            if (r_occ[0] != '0 || r_occ[1] != '0 || r_occ[2] != '0) begin
                                n_cls   = pk.cls;
                                n_hcnt  = pk.hcnt;
                                n_mcnt  = pk.mcnt;
                                n_lflag = pk.lflag;
                                n_state = S_SHIFT;
                            end else begin
                                n_done   = 1'b1;
                                n_status = tcwqs_pkg::ST_NONE;
                                n_oid    = '0;
                                n_oage   = '0;
                                n_ocls   = '0;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = tcwqs_pkg::ST_NONE;
                            n_oid    = '0;
                            n_oage   = '0;
                            n_ocls   = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (r_op == tcwqs_pkg::OP_REGISTER) begin
                        n_done   = 1'b1;
                        n_status = tcwqs_pkg::ST_DUPLICATE;
                        n_oid    = r_id;
                        n_oage   = r_age;
                        n_ocls   = r_cls;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_rd_pos;
                        n_pos   = r_rd_pos;
                        n_state = S_SHIFT;
                    end
                end else if (more) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_pos = r_idx;
                    n_idx    = r_idx + IW'(1);
                end else if (!r_rd_vld) begin
                    if (r_op == tcwqs_pkg::OP_REGISTER) begin
                        n_done  = 1'b1;
                        n_oid   = r_id;
                        n_oage  = r_age;
                        n_ocls  = r_cls;
                        n_state = S_IDLE;
                        if (occ_cur >= DEPTH_I) begin
                            n_status = tcwqs_pkg::ST_FULL;
                        end else begin
                            mem_we       = 1'b1;
                            n_occ[r_cls] = occ_cur + IW'(1);
                            n_status     = tcwqs_pkg::ST_REGISTERED;
                        end
                    end else if (r_cls == tcwqs_pkg::CLS_LOW) begin
                        n_done   = 1'b1;
                        n_status = tcwqs_pkg::ST_NOT_FOUND;
                        n_oid    = '0;
                        n_oage   = '0;
                        n_ocls   = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_cls = r_cls + 2'd1;
                        n_idx = '0;
                    end
                end
            end
            S_SHIFT: begin
                if (r_rd_vld) begin
                    if (r_rd_pos == r_pos) begin
                        n_id  = r_rd_data.id;
                        n_age = r_rd_data.age;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = base + AW'(r_rd_pos - IW'(1));
                        mem_wdata = r_rd_data;
                    end
                end
                if (more) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_pos = r_idx;
                    n_idx    = r_idx + IW'(1);
                end else if (!r_rd_vld) begin
                    n_occ[r_cls] = occ_cur - IW'(1);
                    n_done       = 1'b1;
                    n_status     = (r_op == tcwqs_pkg::OP_SERVE) ? tcwqs_pkg::ST_SERVED
                                                                 : tcwqs_pkg::ST_WITHDRAWN;
                    n_oid        = r_id;
                    n_oage       = r_age;
                    n_ocls       = r_cls;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_occ       <= '{default: '0};
            r_hcnt      <= CW'(1);
            r_mcnt      <= CW'(1);
            r_lflag     <= 2'd1;
            r_done      <= 1'b0;
            r_hi_thr    <= tcwqs_pkg::HIGH_THR_RST;
            r_mid_thr   <= tcwqs_pkg::MID_THR_RST;
            r_hi_turns  <= tcwqs_pkg::HIGH_TURNS_RST;
            r_mid_turns <= tcwqs_pkg::MID_TURNS_RST;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_occ    <= n_occ;
            r_hcnt   <= n_hcnt;
            r_mcnt   <= n_mcnt;
            r_lflag  <= n_lflag;
            r_done   <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcwqs_pkg::REG_HIGH_THR:   r_hi_thr    <= i_cfg_data;
                    tcwqs_pkg::REG_MID_THR:    r_mid_thr   <= i_cfg_data;
                    tcwqs_pkg::REG_HIGH_TURNS: r_hi_turns  <= i_cfg_data[tcwqs_pkg::TURN_W-1:0];
                    tcwqs_pkg::REG_MID_TURNS:  r_mid_turns <= i_cfg_data[tcwqs_pkg::TURN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_id     <= n_id;
        r_age    <= n_age;
        r_cls    <= n_cls;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_rd_pos <= n_rd_pos;
        r_status <= n_status;
        r_oid    <= n_oid;
        r_oage   <= n_oage;
        r_ocls   <= n_ocls;
    end

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ[0] <= DEPTH_I && r_occ[1] <= DEPTH_I && r_occ[2] <= DEPTH_I)
        else $error("class occupancy beyond queue depth");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a transaction is still in progress");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_done) |-> $past(busy) || $past(start))
        else $error("result strobe without a transaction in progress");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_rd_vld) |-> r_rd_pos < occ_cur)
        else $error("shift read beyond class occupancy");

    a_turn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= CW'(16) && r_mcnt <= CW'(16) && r_lflag != 2'd0 && r_lflag != 2'd3)
        else $error("turn counters out of range");

endmodule
